// File: rtl/core/scc_pkg.sv
// Package for the sector cache replacement engine.
// Holds shared constants, codes and controller/datapath command types.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;
    localparam int DEF_CAPACITY = 32;
    localparam int SEC_W = 32;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_DIRTY  = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_WBACK  = 2'd1;
    localparam logic [1:0] KIND_EVICT  = 2'd2;

    // Source of the sector field of a result beat.
    typedef enum logic [1:0] {
        SRC_REQ,      // requested sector
        SRC_CUR,      // entry under the pointer
        SRC_GONE      // evicted sector
    } src_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch request, reset scan pointer
        OP_SCAN_STEP, // advance scan pointer
        OP_SET_USE,   // set use (and dirty if mark) at pointer
        OP_SEEK_TOP,  // point at the last resident entry
        OP_SHIFT_UP,  // copy entry at ptr to ptr+1, step down
        OP_WRITE_NEW, // write new entry at ptr+1, count++, pointer to zero
        OP_HAND_STEP, // advance hand search pointer
        OP_PTR_ZERO,  // pointer back to the first entry
        OP_CLEAN,     // clear dirty at pointer
        OP_AGE,       // clear use at pointer, advance with wrap
        OP_EVICT_MARK,// record eviction, step past the evicted entry
        OP_HAND_LOAD, // hand takes the sector under the pointer
        OP_SHIFT_DOWN // copy entry ptr to ptr-1, step up; at the end count--
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic ptr_at_end;   // ptr >= count
        logic match;        // sector at ptr equals request
        logic above;        // sector at ptr greater than request
        logic over_cap;     // count exceeds capacity
        logic room;         // count below slots
        logic hand_valid;
        logic hand_ge;      // sector at ptr >= hand sector
        logic cur_dirty;
        logic cur_use;
        logic ptr_last;     // ptr + 1 >= count
        logic [1:0] mode;
    } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/scc_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface scc_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/scc_datapath.sv
// Datapath: entry store, count, hand and scan pointer for the sector cache.
// Depends on scc_pkg; driven by scc_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module scc_datapath #(
    parameter int CAPACITY = scc_pkg::DEF_CAPACITY,
    parameter int SLOTS = CAPACITY + 1,
    parameter int IW = $clog2(SLOTS + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire scc_pkg::cmd_t cmd,
    input  wire logic [1:0] req_mode,
    input  wire logic [scc_pkg::SEC_W-1:0] req_sector,
    output scc_pkg::stat_t stat,
    output logic [scc_pkg::SEC_W-1:0] cur_sector,
    output logic [scc_pkg::SEC_W-1:0] gone_sector,
    output logic [scc_pkg::SEC_W-1:0] sector_reg_out
);
    import scc_pkg::*;

    localparam int PW = $clog2(SLOTS);

    logic [SEC_W-1:0] sec_mem [SLOTS];
    logic [SEC_W-1:0] rd_reg;
    logic [SLOTS-1:0] use_reg;
    logic [SLOTS-1:0] dirty_reg;
    logic [IW-1:0] count_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] ptr_next;
    logic [SEC_W-1:0] hand_reg;
    logic hand_valid_reg;
    logic [SEC_W-1:0] req_reg;
    logic [1:0] mode_reg;
    logic [SEC_W-1:0] gone_reg;
    logic [PW-1:0] p;
    logic [PW-1:0] pm1;
    logic [PW-1:0] pp1;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic [IW-1:0] ptr_inc;
    logic wr_en;
    logic [SEC_W-1:0] wr_data;

    assign p = ptr_reg[PW-1:0];
    assign pm1 = p - PW'(1);
    assign pp1 = p + PW'(1);
    assign ptr_inc = ptr_reg + IW'(1);
    assign rd_addr = ptr_next[PW-1:0];
    // The read register always holds the sector of the entry under the pointer.
    assign cur_sector = rd_reg;
    assign gone_sector = gone_reg;
    assign sector_reg_out = req_reg;

    always_comb
    begin
        stat.ptr_at_end = ptr_reg >= count_reg;
        stat.match = rd_reg == req_reg;
        stat.above = rd_reg > req_reg;
        stat.over_cap = count_reg > IW'(CAPACITY);
        stat.room = count_reg < IW'(SLOTS);
        stat.hand_valid = hand_valid_reg;
        stat.hand_ge = rd_reg >= hand_reg;
        stat.cur_dirty = dirty_reg[p];
        stat.cur_use = use_reg[p];
        stat.ptr_last = ptr_inc >= count_reg;
        stat.mode = mode_reg;
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        wr_en = 1'b0;
        wr_addr = pp1;
        wr_data = rd_reg;
        unique case (cmd.op)
            OP_LOAD, OP_PTR_ZERO: ptr_next = '0;
            OP_SCAN_STEP, OP_HAND_STEP, OP_EVICT_MARK: ptr_next = ptr_inc;
            OP_SEEK_TOP: ptr_next = count_reg - IW'(1);
            OP_SHIFT_UP:
            begin
                wr_en = 1'b1;
                ptr_next = ptr_reg - IW'(1);
            end
            OP_WRITE_NEW:
            begin
                wr_en = 1'b1;
                wr_data = req_reg;
                ptr_next = '0;
            end
            OP_AGE: ptr_next = stat.ptr_last ? '0 : ptr_inc;
            OP_SHIFT_DOWN:
                if (!stat.ptr_at_end)
                begin
                    wr_en = 1'b1;
                    wr_addr = pm1;
                    ptr_next = ptr_inc;
                end
            default: ;
        endcase
    end

    // One write port and one registered read port; a read of the address
    // being written returns the new sector.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            sec_mem[wr_addr] <= wr_data;
        if (wr_en && wr_addr == rd_addr)
            rd_reg <= wr_data;
        else
            rd_reg <= sec_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg <= req_sector;
                mode_reg <= req_mode;
            end
            OP_EVICT_MARK: gone_reg <= rd_reg;
            OP_HAND_LOAD: hand_reg <= rd_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
            ptr_reg <= '0;
            hand_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            unique case (cmd.op)
                OP_SET_USE:
                begin
                    use_reg[p] <= 1'b1;
                    if (mode_reg == MODE_DIRTY)
                        dirty_reg[p] <= 1'b1;
                end
                OP_SHIFT_UP:
                begin
                    use_reg[pp1] <= use_reg[p];
                    dirty_reg[pp1] <= dirty_reg[p];
                end
                OP_WRITE_NEW:
                begin
                    use_reg[pp1] <= 1'b1;
                    dirty_reg[pp1] <= 1'b0;
                    count_reg <= count_reg + IW'(1);
                end
                OP_CLEAN: dirty_reg[p] <= 1'b0;
                OP_AGE: use_reg[p] <= 1'b0;
                OP_EVICT_MARK: hand_valid_reg <= !stat.ptr_last;
                OP_SHIFT_DOWN:
                begin
                    if (stat.ptr_at_end)
                    begin
                        count_reg <= count_reg - IW'(1);
                    end
                    else
                    begin
                        use_reg[pm1] <= use_reg[p];
                        dirty_reg[pm1] <= dirty_reg[p];
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(SLOTS))
        else $error("entry count beyond slots");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_WRITE_NEW |-> count_reg < IW'(SLOTS))
        else $error("insert into full store");
    a_evict_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EVICT_MARK |-> ptr_reg < count_reg)
        else $error("eviction outside resident entries");
`endif
endmodule
`default_nettype wire

// File: rtl/core/scc_ctrl.sv
// Controller state machine for the sector cache replacement engine.
// Depends on scc_pkg; commands scc_datapath and drives the result beat.
`timescale 1ns / 1ps
`default_nettype none
module scc_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire scc_pkg::stat_t stat,
    output scc_pkg::cmd_t cmd,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [1:0] out_kind,
    output logic out_hit,
    output logic out_last,
    output scc_pkg::src_t out_src
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_INS_SHIFT, S_HAND, S_SWEEP, S_WB_OUT,
        S_EV_HAND, S_EV_SHIFT, S_EV_OUT, S_DONE_OUT
    } state_t;

    state_t state_reg;
    logic hit_reg;
    logic out_valid_reg;
    logic [1:0] kind_reg;
    src_t src_reg;
    logic found;
    logic scanning;

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_kind = kind_reg;
    assign out_hit = hit_reg && kind_reg == KIND_DONE;
    assign out_last = kind_reg == KIND_DONE;
    assign out_src = src_reg;
    assign found = !stat.ptr_at_end && stat.match;
    assign scanning = !stat.ptr_at_end && !stat.match && !stat.above;

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE: if (in_valid) cmd.op = OP_LOAD;
            S_FIND:
                if (scanning)
                    cmd.op = OP_SCAN_STEP;
                else if (stat.mode == MODE_INSERT)
                begin
                    if (!found && stat.room)
                        cmd.op = OP_SEEK_TOP;
                end
                else if (found && (stat.mode == MODE_LOOKUP || stat.mode == MODE_DIRTY))
                    cmd.op = OP_SET_USE;
            S_INS_SHIFT:
                if (!stat.ptr_at_end && stat.above) cmd.op = OP_SHIFT_UP;
                else cmd.op = OP_WRITE_NEW;
            S_HAND:
                if (stat.over_cap)
                begin
                    if (stat.hand_valid && !stat.ptr_at_end && !stat.hand_ge)
                        cmd.op = OP_HAND_STEP;
                    else if (stat.hand_valid && stat.ptr_at_end)
                        cmd.op = OP_PTR_ZERO; // no entry at or above hand: first entry
                end
            S_SWEEP:
                if (stat.cur_dirty) cmd.op = OP_CLEAN;
                else if (stat.cur_use) cmd.op = OP_AGE;
                else cmd.op = OP_EVICT_MARK;
            S_EV_HAND: cmd.op = OP_HAND_LOAD;
            S_EV_SHIFT: cmd.op = OP_SHIFT_DOWN;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
            kind_reg <= KIND_DONE;
            src_reg <= SRC_REQ;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_FIND;
                        hit_reg <= 1'b0;
                    end
                S_FIND:
                    if (scanning)
                        state_reg <= S_FIND;
                    else if (stat.mode == MODE_INSERT)
                    begin
                        if (!found && stat.room)
                            state_reg <= S_INS_SHIFT;
                        else
                            state_reg <= S_DONE_OUT;
                    end
                    else
                    begin
                        hit_reg <= found && (stat.mode == MODE_LOOKUP
                                             || stat.mode == MODE_DIRTY);
                        state_reg <= S_DONE_OUT;
                    end
                S_INS_SHIFT:
                    if (!(!stat.ptr_at_end && stat.above))
                        state_reg <= S_HAND;
                S_HAND:
                    if (!stat.over_cap) state_reg <= S_DONE_OUT;
                    else if (stat.hand_valid && !stat.ptr_at_end && !stat.hand_ge) ;
                    else state_reg <= S_SWEEP;
                S_SWEEP:
                    if (stat.cur_dirty)
                    begin
                        kind_reg <= KIND_WBACK;
                        src_reg <= SRC_CUR;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_WB_OUT;
                    end
                    else if (!stat.cur_use)
                        state_reg <= S_EV_HAND;
                S_WB_OUT:
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_SWEEP;
                    end
                S_EV_HAND: state_reg <= S_EV_SHIFT;
                S_EV_SHIFT:
                    if (stat.ptr_at_end)
                    begin
                        kind_reg <= KIND_EVICT;
                        src_reg <= SRC_GONE;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_EV_OUT;
                    end
                S_EV_OUT:
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_DONE_OUT;
                    end
                S_DONE_OUT:
                    if (!out_valid_reg)
                    begin
                        kind_reg <= KIND_DONE;
                        src_reg <= SRC_REQ;
                        out_valid_reg <= 1'b1;
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while a result beat is pending");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last |-> state_reg == S_DONE_OUT)
        else $error("final beat outside done state");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(kind_reg))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// File: rtl/core/sector_cache_clock_replacement.sv
// Top level of the sector cache tag and clock replacement engine.
// Depends on scc_pkg, scc_if, scc_ctrl and scc_datapath.
//
// Usage: requests arrive as beats on req (mode, sector). Each request yields
// one or more result beats on res (kind, hit, sector_res, last); the final
// beat of a request has last set and kind "done". An insert that overfills
// the cache first produces write-back beats for dirty entries passed by the
// clock hand, then one eviction beat.
// One request is handled at a time. A lookup or mark-dirty scans from the
// first entry, one entry per cycle, and the next request is taken only after
// the done beat of the current one has been taken.
// An insert adds a shift of the tail, one entry per cycle, a hand search and
// then a sweep that visits one entry per cycle, but holds on a dirty entry until
// its write-back beat is taken, and a compaction of the tail after the evicted entry.
// Reset empties the store and clears the hand; no clearing pass is needed.
// When the receiver stalls, the result beat holds and the engine waits.
`timescale 1ns / 1ps
`default_nettype none
module sector_cache_clock_replacement #(
    parameter int CAPACITY = scc_pkg::DEF_CAPACITY
) (
    input wire logic clk,
    input wire logic rst_n,
    scc_if.sink req,
    scc_if.source res
);
    import scc_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int IW = $clog2(SLOTS + 1);

    cmd_t cmd;
    stat_t stat;
    logic [SEC_W-1:0] cur_sector;
    logic [SEC_W-1:0] gone_sector;
    logic [SEC_W-1:0] req_sector_q;
    logic [1:0] kind;
    logic hit;
    logic last;
    src_t src;

    scc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .stat(stat), .cmd(cmd),
        .out_valid(res.valid), .out_ready(res.ready),
        .out_kind(kind), .out_hit(hit), .out_last(last), .out_src(src)
    );

    scc_datapath #(.CAPACITY(CAPACITY), .SLOTS(SLOTS), .IW(IW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .req_mode(req.data.mode), .req_sector(req.data.sector),
        .stat(stat), .cur_sector(cur_sector), .gone_sector(gone_sector),
        .sector_reg_out(req_sector_q)
    );

    // The write-back beat shows the entry under the sweep pointer, which
    // holds still while the beat waits.
    always_comb
    begin
        res.data.kind = kind;
        res.data.hit = hit;
        res.data.last = last;
        unique case (src)
            SRC_CUR: res.data.sector_res = cur_sector;
            SRC_GONE: res.data.sector_res = gone_sector;
            default: res.data.sector_res = req_sector_q;
        endcase
    end
endmodule
`default_nettype wire
